@@ design/frr_pkg.sv @@
// Package for the fraction remainder rounder.
// Shared widths, status codes, datapath opcodes and controller handshake structs.
package frr_pkg;

  localparam int WORD_BITS = 64;
  localparam int RADIX_W   = 16;
  localparam int PREC_W    = 7;
  localparam int STAT_W    = 2;
  localparam int IDX_W     = 1;
  localparam int DIV_CNT_W = $clog2(WORD_BITS);

  localparam logic [IDX_W-1:0] REG_RADIX  = 1'b0;
  localparam logic [IDX_W-1:0] REG_TARGET = 1'b1;

  localparam logic [RADIX_W-1:0] RADIX_RESET  = 16'd10;
  localparam logic [PREC_W-1:0]  TARGET_RESET = 7'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_DIV0  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RADIX = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_REM_START,
    OP_REM_TAKE,
    OP_ZERO,
    OP_SCALE,
    OP_FRAC_START,
    OP_FRAC_TAKE,
    OP_DROP_START,
    OP_DROP_TAKE,
    OP_POW_INIT,
    OP_POW,
    OP_FIX
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic rem_zero;
    logic scale_more;
    logic drop_more;
    logic rounded;
    logic pow_more;
    logic div_done;
  } stat_t;

endpackage

@@ design/frr_if.sv @@
// Channel interfaces for the fraction remainder rounder.
// Depends on frr_pkg for field widths.
interface frr_req_if;
  logic                          valid;
  logic                          ready;
  logic [frr_pkg::WORD_BITS-1:0] dividend;
  logic [frr_pkg::WORD_BITS-1:0] divisor;
  modport source (output valid, dividend, divisor, input ready);
  modport sink   (input valid, dividend, divisor, output ready);
endinterface

interface frr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [frr_pkg::WORD_BITS-1:0] fraction_digits;
  logic [frr_pkg::PREC_W-1:0]    digit_count;
  logic                          carry_out;
  logic [frr_pkg::STAT_W-1:0]    status;
  modport source (output valid, fraction_digits, digit_count, carry_out, status,
                  input ready);
  modport sink   (input valid, fraction_digits, digit_count, carry_out, status,
                  output ready);
endinterface

interface frr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [frr_pkg::IDX_W-1:0]   index;
  logic [frr_pkg::RADIX_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/frr_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on frr_pkg for the word width.
module frr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [frr_pkg::WORD_BITS-1:0] dividend,
  input  logic [frr_pkg::WORD_BITS-1:0] divisor,
  output logic                          done,
  output logic [frr_pkg::WORD_BITS-1:0] quo,
  output logic [frr_pkg::WORD_BITS-1:0] rem
);
  import frr_pkg::*;

  logic [WORD_BITS-1:0] d;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   diff;
  logic                 ge;

  always_comb begin
    shifted = {rem, quo[WORD_BITS-1]};
    diff    = shifted - {1'b0, d};
    ge      = shifted >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(WORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      d   <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
      quo <= {quo[WORD_BITS-2:0], ge};
    end
  end

endmodule

@@ design/frr_datapath.sv @@
// Datapath: configuration registers, working registers, multiplier and divider.
// Depends on frr_pkg and frr_div.
module frr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  frr_pkg::cmd_t                 cmd,
  output frr_pkg::stat_t                stat,
  input  logic                          cfg_we,
  input  logic [frr_pkg::IDX_W-1:0]     cfg_index,
  input  logic [frr_pkg::RADIX_W-1:0]   cfg_data,
  input  logic [frr_pkg::WORD_BITS-1:0] dividend,
  input  logic [frr_pkg::WORD_BITS-1:0] divisor,
  output logic [frr_pkg::WORD_BITS-1:0] fraction_digits,
  output logic [frr_pkg::PREC_W-1:0]    digit_count,
  output logic                          carry_out,
  output logic [frr_pkg::STAT_W-1:0]    status
);
  import frr_pkg::*;

  logic [RADIX_W-1:0]         radix;
  logic [PREC_W-1:0]          target;
  logic [WORD_BITS-1:0]       num;
  logic [WORD_BITS-1:0]       den;
  logic [WORD_BITS-1:0]       work;
  logic [WORD_BITS-1:0]       frac;
  logic [WORD_BITS-1:0]       base;
  logic [PREC_W-1:0]          prec;
  logic [PREC_W-1:0]          cnt;
  logic                       rounded;
  logic                       carry;
  logic [STAT_W-1:0]          code;

  logic [WORD_BITS+RADIX_W-1:0] scale_prod;
  logic [WORD_BITS+RADIX_W-1:0] pow_prod;
  logic [RADIX_W-1:0]           half;
  logic                         up;
  logic                         fix_ge;
  logic [WORD_BITS-1:0]         fix_frac;

  logic                 div_start;
  logic [WORD_BITS-1:0] div_a;
  logic [WORD_BITS-1:0] div_b;
  logic                 div_done;
  logic [WORD_BITS-1:0] div_quo;
  logic [WORD_BITS-1:0] div_rem;

  always_comb begin
    scale_prod = work * {{WORD_BITS{1'b0}}, radix};
    pow_prod   = base * {{WORD_BITS{1'b0}}, radix};
    half       = (radix >> 1) + {{(RADIX_W-1){1'b0}}, radix[0]};
    up         = div_rem[RADIX_W-1:0] >= half;
    fix_ge     = frac >= base;
    fix_frac   = fix_ge ? frac - base : frac;
    div_start  = 1'b0;
    div_a      = num;
    div_b      = den;
    unique case (cmd.op)
      OP_REM_START:  div_start = 1'b1;
      OP_FRAC_START: begin
        div_start = 1'b1;
        div_a     = work;
      end
      OP_DROP_START: begin
        div_start = 1'b1;
        div_a     = frac;
        div_b     = {{(WORD_BITS-RADIX_W){1'b0}}, radix};
      end
      default: ;
    endcase
  end

  frr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix  <= RADIX_RESET;
      target <= TARGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:  radix  <= cfg_data;
        REG_TARGET: target <= cfg_data[PREC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        num     <= dividend;
        den     <= divisor;
        code    <= ST_OK;
        carry   <= 1'b0;
        rounded <= 1'b0;
        prec    <= '0;
      end
      OP_ERR: begin
        frac <= '0;
        prec <= '0;
        code <= (den == '0) ? ST_DIV0 : ST_RADIX;
      end
      OP_REM_TAKE: work <= div_rem;
      OP_ZERO: begin
        frac <= '0;
        prec <= '0;
      end
      OP_SCALE: begin
        work <= scale_prod[WORD_BITS-1:0];
        prec <= prec + 1'b1;
      end
      OP_FRAC_TAKE: frac <= div_quo;
      OP_DROP_TAKE: begin
        frac    <= div_quo + {{(WORD_BITS-1){1'b0}}, up};
        rounded <= rounded | up;
        prec    <= prec - 1'b1;
      end
      OP_POW_INIT: begin
        base <= {{(WORD_BITS-1){1'b0}}, 1'b1};
        cnt  <= '0;
      end
      OP_POW: begin
        base <= pow_prod[WORD_BITS-1:0];
        cnt  <= cnt + 1'b1;
      end
      OP_FIX: begin
        frac  <= fix_frac;
        carry <= fix_ge;
        if (fix_frac == '0) prec <= '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.bad        = (den == '0) || (radix < RADIX_W'(2));
    stat.rem_zero   = work == '0;
    stat.scale_more = scale_prod[WORD_BITS+RADIX_W-1:WORD_BITS] == '0;
    stat.drop_more  = prec > target;
    stat.rounded    = rounded;
    stat.pow_more   = cnt < prec;
    stat.div_done   = div_done;
  end

  assign fraction_digits = frac;
  assign digit_count     = prec;
  assign carry_out       = carry;
  assign status          = code;

endmodule

@@ design/frr_ctrl.sv @@
// Controller state machine sequencing the datapath for one word at a time.
// Depends on frr_pkg.
module frr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  frr_pkg::stat_t stat,
  output frr_pkg::cmd_t  cmd
);
  import frr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_REM   = 10'b0000000100,
    S_TEST  = 10'b0000001000,
    S_SCALE = 10'b0000010000,
    S_FRAC  = 10'b0000100000,
    S_DROP  = 10'b0001000000,
    S_DROPW = 10'b0010000000,
    S_POW   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: if (req_valid) begin
        cmd.op     = OP_LOAD;
        state_next = S_CHECK;
      end
      S_CHECK: if (stat.bad) begin
        cmd.op     = OP_ERR;
        state_next = S_OUT;
      end else begin
        cmd.op     = OP_REM_START;
        state_next = S_REM;
      end
      S_REM: if (stat.div_done) begin
        cmd.op     = OP_REM_TAKE;
        state_next = S_TEST;
      end
      S_TEST: if (stat.rem_zero) begin
        cmd.op     = OP_ZERO;
        state_next = S_OUT;
      end else begin
        state_next = S_SCALE;
      end
      S_SCALE: if (stat.scale_more) begin
        cmd.op = OP_SCALE;
      end else begin
        cmd.op     = OP_FRAC_START;
        state_next = S_FRAC;
      end
      S_FRAC: if (stat.div_done) begin
        cmd.op     = OP_FRAC_TAKE;
        state_next = S_DROP;
      end
      S_DROP: if (stat.drop_more) begin
        cmd.op     = OP_DROP_START;
        state_next = S_DROPW;
      end else if (stat.rounded) begin
        cmd.op     = OP_POW_INIT;
        state_next = S_POW;
      end else begin
        state_next = S_OUT;
      end
      S_DROPW: if (stat.div_done) begin
        cmd.op     = OP_DROP_TAKE;
        state_next = S_DROP;
      end
      S_POW: if (stat.pow_more) begin
        cmd.op = OP_POW;
      end else begin
        cmd.op     = OP_FIX;
        state_next = S_OUT;
      end
      S_OUT: if (rsp_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign req_ready = state == S_IDLE;
  assign rsp_valid = state == S_OUT;

endmodule

@@ design/fraction_remainder_rounder.sv @@
// Channel   Dir   Handshake       Payload
// req       in    valid/ready     dividend, divisor
// rsp       out   valid/ready     fraction_digits, digit_count, carry_out, status
// cfg       in    valid/ready     index (0 radix, 1 target_digits), data
//
// One word in flight at a time; req.ready is high only when idle.
// Each word runs a remainder division, up to 63 scale steps, a quotient division,
// one division per dropped digit and, if a digit rounded up, a carry check; the
// shared one-bit-per-cycle divider sets most of this.
// Synchronous reset restores radix 10 and target 3; rsp holds while ready is low.
module fraction_remainder_rounder (
  input logic        clk,
  input logic        rst,
  frr_req_if.sink    req,
  frr_rsp_if.source  rsp,
  frr_cfg_if.sink    cfg
);
  import frr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg.ready = 1'b1;

  frr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  frr_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .dividend        (req.dividend),
    .divisor         (req.divisor),
    .fraction_digits (rsp.fraction_digits),
    .digit_count     (rsp.digit_count),
    .carry_out       (rsp.carry_out),
    .status          (rsp.status)
  );

endmodule

@@ design/frr_checker.sv @@
// Port-level checks for the fraction remainder rounder.
// Depends on frr_pkg; bound to the top level below.
module frr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [frr_pkg::WORD_BITS-1:0] fraction_digits,
  input logic [frr_pkg::PREC_W-1:0]    digit_count,
  input logic                          carry_out,
  input logic [frr_pkg::STAT_W-1:0]    status
);
  import frr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(fraction_digits))
    else $error("rsp word dropped while stalled");

  a_one: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("req taken while rsp pending");

  a_err: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |->
      fraction_digits == '0 && digit_count == '0 && !carry_out)
    else $error("error word carries data");

  a_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status == ST_OK || status == ST_DIV0 || status == ST_RADIX)
    else $error("bad status code");

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> digit_count < PREC_W'(WORD_BITS))
    else $error("digit count too large");

endmodule

bind fraction_remainder_rounder frr_checker u_chk (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .fraction_digits (rsp.fraction_digits),
  .digit_count     (rsp.digit_count),
  .carry_out       (rsp.carry_out),
  .status          (rsp.status)
);

@@ bench/tb.sv @@
// Testbench for fraction_remainder_rounder: directed table, then random phases per setting.
// Depends on frr_pkg and the frr_req_if, frr_rsp_if and frr_cfg_if interfaces.
`timescale 1ns / 100ps

module tb;
  import frr_pkg::*;

  localparam int LIMIT_CYCLES = 20000000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [WORD_BITS-1:0] digits;
    logic [PREC_W-1:0]    count;
    logic                 carry;
    logic [STAT_W-1:0]    status;
  } fraction_t;

  typedef struct {
    logic [RADIX_W-1:0]   radix_data;
    logic [RADIX_W-1:0]   target_data;
    logic [WORD_BITS-1:0] dividend;
    logic [WORD_BITS-1:0] divisor;
    bit                   typed;
    fraction_t            want;
  } row_t;

  logic clk;
  logic rst;

  frr_req_if req_ch ();
  frr_rsp_if rsp_ch ();
  frr_cfg_if cfg_ch ();

  fraction_remainder_rounder u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  logic [RADIX_W-1:0] cur_radix;
  logic [PREC_W-1:0]  cur_target;
  fraction_t          pending_fractions[$];
  row_t               rows[$];
  int                 mismatches;
  int                 cycles;
  int                 stall_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic fraction_t predict_fraction(logic [WORD_BITS-1:0] num,
                                                 logic [WORD_BITS-1:0] den,
                                                 logic [RADIX_W-1:0] rdx,
                                                 logic [PREC_W-1:0] tgt);
    logic [WORD_BITS-1:0] rdx64;
    logic [WORD_BITS-1:0] rem;
    logic [WORD_BITS-1:0] lim;
    logic [WORD_BITS-1:0] frac;
    logic [WORD_BITS-1:0] base;
    logic [WORD_BITS-1:0] half;
    int                   prec;
    bit                   rounded;
    bit                   up;
    fraction_t            r;
    r = '0;
    r.status = ST_OK;
    rdx64 = {{(WORD_BITS-RADIX_W){1'b0}}, rdx};
    prec = 0;
    rounded = 1'b0;
    if (den == 0) begin
      r.status = ST_DIV0;
    end else if (rdx < 2) begin
      r.status = ST_RADIX;
    end else begin
      rem = num % den;
      if (rem != 0) begin
        lim = {WORD_BITS{1'b1}} / rdx64;
        while (rem <= lim) begin
          rem = rem * rdx64;
          prec++;
        end
        frac = rem / den;
        half = rdx64 / 2 + rdx64 % 2;
        while (prec > int'(tgt)) begin
          up = (frac % rdx64) >= half;
          rounded = rounded || up;
          frac = frac / rdx64 + (up ? 64'd1 : 64'd0);
          prec--;
        end
        if (rounded) begin
          base = 64'd1;
          for (int i = 0; i < prec; i++) base = base * rdx64;
          if (frac >= base) begin
            frac = frac - base;
            r.carry = 1'b1;
          end
          if (frac == 0) prec = 0;
        end
        r.digits = frac;
        r.count = prec[PREC_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic fraction_t typed_result(logic [WORD_BITS-1:0] digits, int count,
                                             logic [STAT_W-1:0] status);
    fraction_t r;
    r.digits = digits;
    r.count = count[PREC_W-1:0];
    r.carry = 1'b0;
    r.status = status;
    return r;
  endfunction

  task automatic add_row(logic [RADIX_W-1:0] rdx, logic [RADIX_W-1:0] tgt,
                         logic [WORD_BITS-1:0] num, logic [WORD_BITS-1:0] den,
                         bit typed, fraction_t want);
    row_t r;
    r.radix_data = rdx;
    r.target_data = tgt;
    r.dividend = num;
    r.divisor = den;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  // drain, settle, then write one register
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [RADIX_W-1:0] data);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_fractions.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_RADIX) cur_radix = data;
    else cur_target = data[PREC_W-1:0];
  endtask

  task automatic send_word(logic [WORD_BITS-1:0] num, logic [WORD_BITS-1:0] den,
                           bit typed, fraction_t want);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.dividend <= num;
    req_ch.divisor <= den;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_fractions.push_back(typed ? want : predict_fraction(num, den, cur_radix, cur_target));
  endtask

  function automatic logic [WORD_BITS-1:0] draw_dividend();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return {$urandom, $urandom};
    if (sel <= 7) return 64'($urandom_range(0, 1000));
    if (sel == 8) return {WORD_BITS{1'b1}} - 64'($urandom_range(0, 1000));
    return '0;
  endfunction

  function automatic logic [WORD_BITS-1:0] draw_divisor();
    int sel;
    sel = $urandom_range(0, 29);
    if (sel == 0) return '0;
    if (sel <= 12) return {$urandom, $urandom};
    if (sel <= 20) return 64'($urandom_range(1, 1000));
    if (sel <= 25) return (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 3));
    return {WORD_BITS{1'b1}} - 64'($urandom_range(0, 1000));
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // response side: random stall after each word, compare against oldest expectation
  always @(posedge clk) begin
    int next_stall;
    fraction_t got;
    fraction_t exp_f;
    next_stall = stall_left;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.digits = rsp_ch.fraction_digits;
        got.count = rsp_ch.digit_count;
        got.carry = rsp_ch.carry_out;
        got.status = rsp_ch.status;
        if (pending_fractions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %p", got);
        end else begin
          exp_f = pending_fractions.pop_front();
          if (got.digits !== exp_f.digits || got.count !== exp_f.count ||
              got.carry !== exp_f.carry || got.status !== exp_f.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       exp_f.digits, exp_f.count, exp_f.carry, exp_f.status,
                       got.digits, got.count, got.carry, got.status);
          end
        end
        next_stall = $urandom_range(0, 3);
      end else if (next_stall > 0) begin
        next_stall--;
      end
      stall_left <= next_stall;
      rsp_ch.ready <= (next_stall == 0);
    end
  end

  typedef struct {
    int rlo;
    int rhi;
    int tlo;
    int thi;
    int count;
  } phase_t;

  phase_t phases[$];

  initial begin
    fraction_t z;
    logic [WORD_BITS-1:0] mx;
    phase_t p;
    z = '0;
    mx = {WORD_BITS{1'b1}};
    rst = 1'b1;
    cycles = 0;
    mismatches = 0;
    stall_left = 0;
    cur_radix = RADIX_RESET;
    cur_target = TARGET_RESET;
    req_ch.valid = 1'b0;
    req_ch.dividend = '0;
    req_ch.divisor = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_RADIX;
    cfg_ch.data = '0;

    add_row(10, 3, 64'd7, 64'd0, 1, typed_result(0, 0, ST_DIV0));
    add_row(10, 3, 64'd0, 64'd1, 1, typed_result(0, 0, ST_OK));
    add_row(10, 3, mx, mx, 1, typed_result(0, 0, ST_OK));
    add_row(10, 3, 64'd1, 64'd2, 1, typed_result(500, 3, ST_OK));
    add_row(10, 3, 64'd2, 64'd3, 0, z);
    add_row(10, 3, 64'd9999, 64'd10000, 0, z);
    add_row(10, 3, mx, mx - 1, 0, z);
    add_row(10, 3, 64'd1, 64'd3, 0, z);
    add_row(10, 3, 64'd1, 64'd100000, 0, z);
    add_row(10, 3, 64'h8000_0000_0000_0000, mx, 0, z);
    add_row(0, 3, 64'd5, 64'd7, 1, typed_result(0, 0, ST_RADIX));
    add_row(0, 3, 64'd5, 64'd0, 1, typed_result(0, 0, ST_DIV0));
    add_row(1, 3, 64'd5, 64'd7, 1, typed_result(0, 0, ST_RADIX));
    add_row(2, 0, 64'd1, 64'd3, 0, z);
    add_row(2, 0, mx, mx - 1, 0, z);
    add_row(2, 0, 64'd3, 64'd4, 0, z);
    add_row(65535, 64, 64'd12345, 64'd65521, 0, z);
    add_row(65535, 64, 64'd1, 64'd2, 0, z);
    add_row(2, 16'hFFFF, 64'd1, 64'd3, 0, z);
    add_row(65534, 1, mx, 64'd3, 0, z);
    add_row(65534, 1, 64'd1, mx, 0, z);
    add_row(3, 0, 64'd2, 64'd3, 0, z);

    phases = '{
      '{2, 2, 0, 0, 15},      '{10, 10, 3, 3, 100},   '{65535, 65535, 0, 1, 40},
      '{2, 65535, 50, 64, 300}, '{0, 1, 0, 127, 20},  '{2, 300, 10, 40, 150},
      '{3, 65535, 0, 127, 60}, '{16, 16, 16, 16, 100}, '{2, 2, 60, 63, 100},
      '{10, 10, 18, 19, 100}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].radix_data != cur_radix) write_reg(REG_RADIX, rows[i].radix_data);
      if (rows[i].target_data[PREC_W-1:0] != cur_target)
        write_reg(REG_TARGET, rows[i].target_data);
      send_word(rows[i].dividend, rows[i].divisor, rows[i].typed, rows[i].want);
    end

    foreach (phases[k]) begin
      p = phases[k];
      write_reg(REG_RADIX, 16'($urandom_range(p.rlo, p.rhi)));
      write_reg(REG_TARGET, {9'($urandom_range(0, 511)), 7'($urandom_range(p.tlo, p.thi))});
      repeat (p.count) send_word(draw_dividend(), draw_divisor(), 0, z);
    end

    req_ch.valid <= 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
